// ----- rtl/rsts_pkg.sv -----
// shared types and codes for the remote segment translate and split block
// no dependencies; the interface, segment table and top-level files import this package
package rsts_pkg;

  localparam int unsigned AddrW   = 64;
  localparam int unsigned EntryW  = 4;
  localparam int unsigned StatusW = 3;

  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic [StatusW-1:0] {
    ST_CHUNK    = 3'd0,
    ST_WRITTEN  = 3'd1,
    ST_ZERO_LEN = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_NOT_REG  = 3'd4
  } status_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_XLATE = 1'b1
  } op_e;

  // one table entry as stored in the segment memory
  typedef struct packed {
    addr_t base;
    addr_t len;
    addr_t va;
  } seg_t;

  typedef struct packed {
    logic              en;
    logic [EntryW-1:0] idx;
    seg_t              seg;
    logic              valid;
  } tbl_wr_t;

  typedef struct packed {
    logic  start;
    addr_t addr;
  } srch_req_t;

  typedef struct packed {
    logic  done;
    logic  found;
    addr_t mapped;
    addr_t avail;
  } srch_rsp_t;

endpackage

// ----- rtl/rsts_if.sv -----
// valid/ready channel interfaces for the request and result streams
// depends on rsts_pkg
interface rsts_req_if import rsts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [EntryW-1:0] entry_index;
  addr_t             seg_base;
  addr_t             seg_len;
  addr_t             seg_va;
  logic              seg_valid;
  addr_t             lcl_addr;
  addr_t             rmt_addr;
  addr_t             xfer_len;

  modport source (
    output valid, op, entry_index, seg_base, seg_len, seg_va, seg_valid,
           lcl_addr, rmt_addr, xfer_len,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, seg_base, seg_len, seg_va, seg_valid,
           lcl_addr, rmt_addr, xfer_len,
    output ready
  );
endinterface

interface rsts_rsp_if import rsts_pkg::*; ();
  logic               valid;
  logic               ready;
  addr_t              out_lcl_addr;
  addr_t              out_rmt_addr;
  addr_t              out_len;
  logic [StatusW-1:0] status;
  logic               last;

  modport source (
    output valid, out_lcl_addr, out_rmt_addr, out_len, status, last,
    input  ready
  );
  modport sink (
    input  valid, out_lcl_addr, out_rmt_addr, out_len, status, last,
    output ready
  );
endinterface

// ----- rtl/rsts_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module rsts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rsts_seg_table.sv -----
// segment table: entry memory, valid bits and the sweep that finds the
// covering segment with the largest base; depends on rsts_pkg and rsts_ram
module rsts_seg_table import rsts_pkg::*; #(
  parameter int unsigned SEGMENTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tbl_wr_t   wr_i,
  input  srch_req_t req_i,
  output srch_rsp_t rsp_o
);

  localparam int unsigned IdxW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SEGMENTS - 1);

  logic [SEGMENTS-1:0] valid_q;
  logic [IdxW-1:0]     wr_idx;

  logic            busy_q;
  logic [IdxW-1:0] rd_idx_q;
  addr_t           addr_q;

  logic            p0_vld_q, p0_last_q;
  logic [IdxW-1:0] p0_idx_q;
  logic [$bits(seg_t)-1:0] rdata;
  seg_t            rd_seg;

  logic [AddrW:0]  diff;
  logic            s1_ok_q, s1_vld_q, s1_last_q;
  addr_t           s1_off_q, s1_base_q, s1_len_q, s1_va_q;

  logic [AddrW:0]  sum;
  logic            in_len;
  logic            s2_ok_q, s2_vld_q, s2_last_q;
  addr_t           s2_base_q, s2_map_q, s2_avail_q;

  logic            upd;
  logic            found_q, done_q;
  addr_t           best_base_q, best_map_q, best_avail_q;

  assign wr_idx = IdxW'(wr_i.idx);

  rsts_ram #(
    .Width ($bits(seg_t)),
    .Depth (SEGMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_idx),
    .wdata_i (wr_i.seg),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  assign rd_seg = seg_t'(rdata);

  // stage 1: offset from the segment base, borrow means base above address
  assign diff = {1'b0, addr_q} - {1'b0, rd_seg.base};
  // stage 2: inside the segment and mapped address does not wrap
  assign in_len = s1_off_q < s1_len_q;
  assign sum    = {1'b0, s1_va_q} + {1'b0, s1_off_q};
  // stage 3: strict compare keeps the lowest index on equal bases
  assign upd = s2_vld_q && s2_ok_q && (!found_q || (s2_base_q > best_base_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      busy_q    <= 1'b0;
      rd_idx_q  <= '0;
      p0_vld_q  <= 1'b0;
      p0_last_q <= 1'b0;
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
      found_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_idx] <= wr_i.valid;
      end
      if (req_i.start) begin
        busy_q   <= 1'b1;
        rd_idx_q <= '0;
      end else if (busy_q) begin
        if (rd_idx_q == LastIdx) begin
          busy_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + IdxW'(1);
        end
      end
      p0_vld_q  <= busy_q && !req_i.start;
      p0_last_q <= busy_q && !req_i.start && (rd_idx_q == LastIdx);
      s1_vld_q  <= p0_vld_q;
      s1_last_q <= p0_vld_q && p0_last_q;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_vld_q && s1_last_q;
      if (req_i.start) begin
        found_q <= 1'b0;
      end else if (upd) begin
        found_q <= 1'b1;
      end
      done_q <= s2_vld_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      addr_q <= req_i.addr;
    end
    p0_idx_q   <= rd_idx_q;
    s1_ok_q    <= valid_q[p0_idx_q] && !diff[AddrW];
    s1_off_q   <= diff[AddrW-1:0];
    s1_base_q  <= rd_seg.base;
    s1_len_q   <= rd_seg.len;
    s1_va_q    <= rd_seg.va;
    s2_ok_q    <= s1_ok_q && in_len && !sum[AddrW];
    s2_base_q  <= s1_base_q;
    s2_map_q   <= sum[AddrW-1:0];
    s2_avail_q <= s1_len_q - s1_off_q;
    if (upd) begin
      best_base_q  <= s2_base_q;
      best_map_q   <= s2_map_q;
      best_avail_q <= s2_avail_q;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.found  = found_q;
  assign rsp_o.mapped = best_map_q;
  assign rsp_o.avail  = best_avail_q;

endmodule

// ----- rtl/remote_segment_translate_split.sv -----
// top level: item sequencer, chunk splitter and result register
// depends on rsts_pkg, rsts_if and rsts_seg_table
//
// Requests arrive on req_i (valid/ready). A write beat (op 0) loads one
// table entry and returns one result with status written. A translate beat
// (op 1) is checked for zero length and address wrap, then split into chunks;
// each chunk sweeps the whole segment memory, one entry per cycle through a
// three-stage compare pipeline, to find the covering segment with the
// largest base. Results leave on rsp_o (valid/ready), the final one of each
// request marked with last.
// A write, zero-length or wrap result is set up in the pending registers in
// S_CHECK and moves into the output register in S_EMIT. Each chunk waits in
// S_SEARCH for the full memory sweep, then passes S_CHUNK and S_EMIT. One
// request is worked on at a time; req_i is ready again once its final result
// has entered the output register. Reset clears all valid bits, so no segment
// is registered; the memory itself needs no clearing. A stalled rsp_o holds
// the result register and the sequencer waits, with nothing lost or repeated.
module remote_segment_translate_split import rsts_pkg::*; #(
  parameter int unsigned SEGMENTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rsts_req_if.sink          req_i,
  rsts_rsp_if.source        rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_CHUNK,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  op_e               op_q, op_d;
  logic [EntryW-1:0] idx_q, idx_d;
  seg_t              seg_q, seg_d;
  logic              segv_q, segv_d;
  addr_t             la_q, la_d;
  addr_t             ra_q, ra_d;
  addr_t             rest_q, rest_d;
  addr_t             map_q, map_d;
  addr_t             avail_q, avail_d;

  addr_t             pla_q, pla_d;
  addr_t             pra_q, pra_d;
  addr_t             plen_q, plen_d;
  status_e           pst_q, pst_d;
  logic              plast_q, plast_d;

  logic              ovld_q, ovld_d;
  addr_t             ola_q, ola_d;
  addr_t             ora_q, ora_d;
  addr_t             olen_q, olen_d;
  status_e           ost_q, ost_d;
  logic              olast_q, olast_d;

  tbl_wr_t           tbl_wr;
  srch_req_t         srch_req;
  srch_rsp_t         srch_rsp;

  logic [AddrW:0]    sum_l, sum_r;
  logic              short_run;
  addr_t             chunk;

  rsts_seg_table #(
    .SEGMENTS (SEGMENTS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (tbl_wr),
    .req_i  (srch_req),
    .rsp_o  (srch_rsp)
  );

  assign sum_l     = {1'b0, la_q} + {1'b0, rest_q};
  assign sum_r     = {1'b0, ra_q} + {1'b0, rest_q};
  assign short_run = rest_q <= avail_q;
  assign chunk     = short_run ? rest_q : avail_q;

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    idx_d   = idx_q;
    seg_d   = seg_q;
    segv_d  = segv_q;
    la_d    = la_q;
    ra_d    = ra_q;
    rest_d  = rest_q;
    map_d   = map_q;
    avail_d = avail_q;
    pla_d   = pla_q;
    pra_d   = pra_q;
    plen_d  = plen_q;
    pst_d   = pst_q;
    plast_d = plast_q;
    ola_d   = ola_q;
    ora_d   = ora_q;
    olen_d  = olen_q;
    ost_d   = ost_q;
    olast_d = olast_q;
    ovld_d  = ovld_q && !rsp_o.ready;

    tbl_wr.en    = 1'b0;
    tbl_wr.idx   = idx_q;
    tbl_wr.seg   = seg_q;
    tbl_wr.valid = segv_q;
    srch_req.start = 1'b0;
    srch_req.addr  = ra_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d       = op_e'(req_i.op);
          idx_d      = req_i.entry_index;
          seg_d.base = req_i.seg_base;
          seg_d.len  = req_i.seg_len;
          seg_d.va   = req_i.seg_va;
          segv_d     = req_i.seg_valid;
          la_d       = req_i.lcl_addr;
          ra_d       = req_i.rmt_addr;
          rest_d     = req_i.xfer_len;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        pla_d   = '0;
        pra_d   = '0;
        plen_d  = '0;
        plast_d = 1'b1;
        state_d = S_EMIT;
        priority if (op_q == OP_WRITE) begin
          // out-of-range index is acknowledged but leaves the table alone
          tbl_wr.en = 32'(idx_q) < 32'(SEGMENTS);
          pst_d     = ST_WRITTEN;
        end else if (rest_q == '0) begin
          pst_d = ST_ZERO_LEN;
        end else if (sum_l[AddrW] || sum_r[AddrW]) begin
          pst_d = ST_OVERFLOW;
        end else begin
          srch_req.start = 1'b1;
          state_d        = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (srch_rsp.done) begin
          if (srch_rsp.found) begin
            map_d   = srch_rsp.mapped;
            avail_d = srch_rsp.avail;
            state_d = S_CHUNK;
          end else begin
            pla_d   = la_q;
            pra_d   = ra_q;
            plen_d  = '0;
            pst_d   = ST_NOT_REG;
            plast_d = 1'b1;
            state_d = S_EMIT;
          end
        end
      end
      S_CHUNK: begin
        pla_d   = la_q;
        pra_d   = map_q;
        plen_d  = chunk;
        pst_d   = ST_CHUNK;
        plast_d = short_run;
        la_d    = la_q + chunk;
        ra_d    = ra_q + chunk;
        rest_d  = rest_q - chunk;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!ovld_q || rsp_o.ready) begin
          ovld_d  = 1'b1;
          ola_d   = pla_q;
          ora_d   = pra_q;
          olen_d  = plen_q;
          ost_d   = pst_q;
          olast_d = plast_q;
          if (plast_q) begin
            state_d = S_IDLE;
          end else begin
            // next chunk starts at the already advanced remote address
            srch_req.start = 1'b1;
            state_d        = S_SEARCH;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
      op_q    <= OP_WRITE;
      idx_q   <= '0;
      seg_q   <= '0;
      segv_q  <= 1'b0;
      la_q    <= '0;
      ra_q    <= '0;
      rest_q  <= '0;
      map_q   <= '0;
      avail_q <= '0;
      pla_q   <= '0;
      pra_q   <= '0;
      plen_q  <= '0;
      pst_q   <= ST_CHUNK;
      plast_q <= 1'b0;
      ola_q   <= '0;
      ora_q   <= '0;
      olen_q  <= '0;
      ost_q   <= ST_CHUNK;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      seg_q   <= seg_d;
      segv_q  <= segv_d;
      la_q    <= la_d;
      ra_q    <= ra_d;
      rest_q  <= rest_d;
      map_q   <= map_d;
      avail_q <= avail_d;
      pla_q   <= pla_d;
      pra_q   <= pra_d;
      plen_q  <= plen_d;
      pst_q   <= pst_d;
      plast_q <= plast_d;
      ola_q   <= ola_d;
      ora_q   <= ora_d;
      olen_q  <= olen_d;
      ost_q   <= ost_d;
      olast_q <= olast_d;
    end
  end

  assign rsp_o.valid        = ovld_q;
  assign rsp_o.out_lcl_addr = ola_q;
  assign rsp_o.out_rmt_addr = ora_q;
  assign rsp_o.out_len      = olen_q;
  assign rsp_o.status       = ost_q;
  assign rsp_o.last         = olast_q;

endmodule
